// ===== sv/gcr_pkg.sv =====
// Shared constants and map addressing helpers for the grid ray caster.
`default_nettype none
package gcr_pkg;

    localparam int MAP_CELLS = 64;
    localparam int CELL_PIX  = 64;
    localparam int PIX_SH    = 6;
    localparam int MAP_LIM   = MAP_CELLS * CELL_PIX;
    localparam int MAP_DEPTH = MAP_CELLS * MAP_CELLS;
    localparam int CELL_W    = $clog2(MAP_CELLS);
    localparam int ADDR_W    = $clog2(MAP_DEPTH);
    localparam int CV_W      = 8;

    localparam int MAX_STEPS = 1024;
    localparam int STEP_W    = $clog2(MAX_STEPS);

    localparam int ORG_W = 14;
    localparam int TRIG_W = 18;
    localparam int POS_W = 36;
    localparam int NUM_W = 54;
    localparam int DEN_W = TRIG_W;
    localparam int LEN_W = 32;
    localparam int ONE_SH = 16;
    localparam int DIST_W = 31;
    localparam int OUT_POS_W = 15;
    localparam int OFS_W = 6;

    localparam logic [1:0] STAT_WRITTEN = 2'd0;
    localparam logic [1:0] STAT_ESCAPED = 2'd1;
    localparam logic [1:0] STAT_HIT     = 2'd2;

    function automatic logic pos_in_map(input logic signed [POS_W-1:0] pos);
        return !pos[POS_W-1] && (pos < POS_W'(MAP_LIM));
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [POS_W-1:0] px,
                                                   input logic [POS_W-1:0] py);
        logic [ADDR_W-1:0] row;
        row = ADDR_W'(ADDR_W'(py[PIX_SH +: CELL_W]) * ADDR_W'(MAP_CELLS));
        return ADDR_W'(row + ADDR_W'(px[PIX_SH +: CELL_W]));
    endfunction

endpackage
`default_nettype wire

// ===== sv/gcr_map_ram.sv =====
// Generic simple dual-port RAM with registered read data.
`default_nettype none
module gcr_map_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 8,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

// ===== sv/gcr_divider.sv =====
// Serial signed divider, one quotient bit per cycle, truncating toward zero.
`default_nettype none
module gcr_divider (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_start,
    input  wire logic signed [gcr_pkg::NUM_W-1:0]  i_num,
    input  wire logic signed [gcr_pkg::DEN_W-1:0]  i_den,
    output logic signed      [gcr_pkg::NUM_W-1:0]  o_quo,
    output logic                                   o_done
);
    import gcr_pkg::*;

    localparam int CNT_W = $clog2(NUM_W);

    logic [NUM_W-1:0] r_q;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W-1:0] r_rem;
    logic [CNT_W-1:0] r_cnt;
    logic             r_neg;
    logic             r_busy;
    logic             r_done;
    logic [DEN_W:0]   w_trial;
    logic [DEN_W:0]   w_diff;
    logic             w_ge;

    assign w_trial = {r_rem, r_q[NUM_W-1]};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign w_ge    = !w_diff[DEN_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_q    <= i_num[NUM_W-1] ? NUM_W'(-i_num) : NUM_W'(i_num);
                r_den  <= i_den[DEN_W-1] ? DEN_W'(-i_den) : DEN_W'(i_den);
                r_neg  <= i_num[NUM_W-1] ^ i_den[DEN_W-1];
                r_rem  <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= w_ge ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
                r_q   <= {r_q[NUM_W-2:0], w_ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_quo  = r_neg ? -$signed(r_q) : $signed(r_q);
    assign o_done = r_done;
endmodule
`default_nettype wire

// ===== sv/grid_ray_caster_top.sv =====
// Grid ray caster: map memory, step sequencer and result register.
//
// Input channel (i_valid / o_ready) takes one item: i_func 0 writes i_cell_value
// to the cell holding (i_origin_x, i_origin_y), i_func 1 casts a ray from that
// origin along (i_cosine, i_sine) in 1.16 format. Output channel
// (o_valid / i_ready) returns one result per item: status, end position,
// hit type, distance and texture offset.
// One item is in work at a time. A cast walks the ray cell boundary by cell
// boundary; each boundary step runs three passes of the shared serial divider
// plus a map read, and a hit adds one more divider pass for the distance. A
// cast ends after at most 1024 steps.
// After reset the map is cleared one cell a cycle, every cell in turn, with o_ready
// low. A finished result waits in the output register; while the receiver
// stalls the block still takes the next item, but holds that item's result
// back until the register is free.
`default_nettype none
module grid_ray_caster_top (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_valid,
    output logic                                       o_ready,
    input  wire logic                                  i_func,
    input  wire logic signed [gcr_pkg::ORG_W-1:0]      i_origin_x,
    input  wire logic signed [gcr_pkg::ORG_W-1:0]      i_origin_y,
    input  wire logic signed [gcr_pkg::TRIG_W-1:0]     i_sine,
    input  wire logic signed [gcr_pkg::TRIG_W-1:0]     i_cosine,
    input  wire logic signed [gcr_pkg::CV_W-1:0]       i_cell_value,
    output logic                                       o_valid,
    input  wire logic                                  i_ready,
    output logic             [1:0]                     o_status,
    output logic signed      [gcr_pkg::OUT_POS_W-1:0]  o_hit_x,
    output logic signed      [gcr_pkg::OUT_POS_W-1:0]  o_hit_y,
    output logic signed      [gcr_pkg::CV_W-1:0]       o_hit_type,
    output logic             [gcr_pkg::DIST_W-1:0]     o_distance,
    output logic             [gcr_pkg::OFS_W-1:0]      o_texture_offset
);
    import gcr_pkg::*;

    typedef enum logic [13:0] {
        ST_CLEAR      = 14'b00000000000001,
        ST_IDLE       = 14'b00000000000010,
        ST_WRITE      = 14'b00000000000100,
        ST_YLEN_GO    = 14'b00000000001000,
        ST_YLEN_WAIT  = 14'b00000000010000,
        ST_XLEN_GO    = 14'b00000000100000,
        ST_XLEN_WAIT  = 14'b00000001000000,
        ST_CROSS_GO   = 14'b00000010000000,
        ST_CROSS_WAIT = 14'b00000100000000,
        ST_READ       = 14'b00001000000000,
        ST_CHECK      = 14'b00010000000000,
        ST_DIST_GO    = 14'b00100000000000,
        ST_DIST_WAIT  = 14'b01000000000000,
        ST_DONE       = 14'b10000000000000
    } t_state;

    t_state r_state;

    logic signed [POS_W-1:0]  r_rx, r_ry;
    logic signed [ORG_W-1:0]  r_x0, r_y0;
    logic signed [TRIG_W-1:0] r_s, r_c;
    logic                     r_s_tgt, r_c_tgt;
    logic [LEN_W-1:0]         r_ylen, r_xlen;
    logic                     r_xstep;
    logic signed [CV_W-1:0]   r_val;
    logic signed [CV_W-1:0]   r_hit;
    logic [STEP_W-1:0]        r_steps;
    logic                     r_inmap;
    logic [1:0]               r_status;
    logic [DIST_W-1:0]        r_dist;
    logic [OFS_W-1:0]         r_ofs;
    logic [ADDR_W-1:0]        r_clr;

    logic                     r_out_valid;
    logic [1:0]               r_o_status;
    logic [OUT_POS_W-1:0]     r_o_x, r_o_y;
    logic [CV_W-1:0]          r_o_type;
    logic [DIST_W-1:0]        r_o_dist;
    logic [OFS_W-1:0]         r_o_ofs;

    logic signed [7:0]        w_dyb, w_dxb;
    logic signed [25:0]       w_px, w_py;
    logic signed [POS_W-1:0]  w_ddx, w_ddy;
    logic                     w_xstep;
    logic                     w_div_start;
    logic signed [NUM_W-1:0]  w_num;
    logic signed [DEN_W-1:0]  w_den;
    logic signed [NUM_W-1:0]  w_quo;
    logic                     w_div_done;
    logic                     w_we;
    logic [ADDR_W-1:0]        w_waddr;
    logic [CV_W-1:0]          w_wdata;
    logic                     w_re;
    logic [CV_W-1:0]          w_rdata;
    logic signed [CV_W-1:0]   w_hit;
    logic                     w_hit_wall;
    logic                     w_escape;
    logic                     w_out_free;
    logic                     w_cell_ok;

    assign w_dyb = (r_s_tgt ? 8'sd64 : -8'sd1) - $signed({2'b00, r_ry[5:0]});
    assign w_dxb = (r_c_tgt ? 8'sd64 : -8'sd1) - $signed({2'b00, r_rx[5:0]});
    assign w_px  = w_dxb * r_s;
    assign w_py  = w_dyb * r_c;
    assign w_ddx = r_rx - POS_W'(r_x0);
    assign w_ddy = r_ry - POS_W'(r_y0);
    assign w_xstep = r_xlen < r_ylen;
    assign w_cell_ok = pos_in_map(r_rx) && pos_in_map(r_ry);

    always_comb begin
        w_div_start = 1'b0;
        w_num = '0;
        w_den = TRIG_W'(1);
        unique case (r_state)
            ST_YLEN_GO: begin
                w_div_start = 1'b1;
                w_num = NUM_W'(w_dyb) <<< ONE_SH;
                w_den = r_s;
            end
            ST_XLEN_GO: begin
                w_div_start = 1'b1;
                w_num = NUM_W'(w_dxb) <<< ONE_SH;
                w_den = r_c;
            end
            ST_CROSS_GO: begin
                w_div_start = 1'b1;
                w_num = w_xstep ? NUM_W'(w_px) : NUM_W'(w_py);
                w_den = w_xstep ? r_c : r_s;
            end
            ST_DIST_GO: begin
                w_div_start = 1'b1;
                w_num = r_xstep ? (NUM_W'(w_ddx) <<< ONE_SH) : (NUM_W'(w_ddy) <<< ONE_SH);
                w_den = r_xstep ? r_c : r_s;
            end
            default: begin
                w_div_start = 1'b0;
            end
        endcase
    end

    gcr_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_quo   (w_quo),
        .o_done  (w_div_done)
    );

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_clr;
        w_wdata = '0;
        if (r_state == ST_CLEAR) begin
            w_we = 1'b1;
        end else if (r_state == ST_WRITE) begin
            w_we    = w_cell_ok;
            w_waddr = cell_addr(r_rx, r_ry);
            w_wdata = r_val;
        end
    end

    assign w_re = (r_state == ST_READ) && w_cell_ok;

    gcr_map_ram #(
        .DEPTH (MAP_DEPTH),
        .WIDTH (CV_W),
        .AW    (ADDR_W)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (cell_addr(r_rx, r_ry)),
        .o_rdata (w_rdata)
    );

    assign w_hit      = r_inmap ? $signed(w_rdata) : -8'sd1;
    assign w_hit_wall = !w_hit[CV_W-1] && (w_hit != '0);
    assign w_escape   = (w_hit == -8'sd1) &&
                        (( r_s[TRIG_W-1] && r_ry[POS_W-1]) ||
                         (!r_s[TRIG_W-1] && (r_ry >= POS_W'(MAP_LIM))) ||
                         ( r_c[TRIG_W-1] && r_rx[POS_W-1]) ||
                         (!r_c[TRIG_W-1] && (r_rx >= POS_W'(MAP_LIM))));
    assign w_out_free = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if ((r_state == ST_DONE) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == ADDR_W'(MAP_DEPTH - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (i_valid) begin
                        r_rx    <= POS_W'(i_origin_x);
                        r_ry    <= POS_W'(i_origin_y);
                        r_x0    <= i_origin_x;
                        r_y0    <= i_origin_y;
                        r_s     <= (i_sine == '0) ? TRIG_W'(1) : i_sine;
                        r_c     <= (i_cosine == '0) ? TRIG_W'(1) : i_cosine;
                        r_s_tgt <= i_sine > 0;
                        r_c_tgt <= i_cosine > 0;
                        r_val   <= i_cell_value;
                        r_hit   <= '0;
                        r_dist  <= '0;
                        r_ofs   <= '0;
                        r_steps <= '0;
                        r_status <= STAT_ESCAPED;
                        r_state <= i_func ? ST_YLEN_GO : ST_WRITE;
                    end
                end
                ST_WRITE: begin
                    r_rx     <= '0;
                    r_ry     <= '0;
                    r_status <= STAT_WRITTEN;
                    r_state  <= ST_DONE;
                end
                ST_YLEN_GO:  r_state <= ST_YLEN_WAIT;
                ST_YLEN_WAIT: begin
                    if (w_div_done) begin
                        r_ylen  <= w_quo[LEN_W-1:0];
                        r_state <= ST_XLEN_GO;
                    end
                end
                ST_XLEN_GO:  r_state <= ST_XLEN_WAIT;
                ST_XLEN_WAIT: begin
                    if (w_div_done) begin
                        r_xlen  <= w_quo[LEN_W-1:0];
                        r_state <= ST_CROSS_GO;
                    end
                end
                ST_CROSS_GO: begin
                    r_xstep <= w_xstep;
                    r_state <= ST_CROSS_WAIT;
                end
                ST_CROSS_WAIT: begin
                    if (w_div_done) begin
                        if (r_xstep) begin
                            r_rx <= r_rx + POS_W'(w_dxb);
                            r_ry <= r_ry + w_quo[POS_W-1:0];
                        end else begin
                            r_rx <= r_rx + w_quo[POS_W-1:0];
                            r_ry <= r_ry + POS_W'(w_dyb);
                        end
                        r_state <= ST_READ;
                    end
                end
                ST_READ: begin
                    r_inmap <= w_cell_ok;
                    r_state <= ST_CHECK;
                end
                ST_CHECK: begin
                    r_hit <= w_hit;
                    priority if (w_hit_wall) begin
                        r_ofs    <= r_xstep ? r_ry[OFS_W-1:0] : r_rx[OFS_W-1:0];
                        r_status <= STAT_HIT;
                        r_state  <= ST_DIST_GO;
                    end else if (w_escape || (r_steps == STEP_W'(MAX_STEPS - 1))) begin
                        r_status <= STAT_ESCAPED;
                        r_state  <= ST_DONE;
                    end else begin
                        r_steps <= r_steps + 1'b1;
                        r_state <= ST_YLEN_GO;
                    end
                end
                ST_DIST_GO:  r_state <= ST_DIST_WAIT;
                ST_DIST_WAIT: begin
                    if (w_div_done) begin
                        r_dist  <= w_quo[DIST_W-1:0];
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (w_out_free) begin
                        r_o_status  <= r_status;
                        r_o_x       <= r_rx[OUT_POS_W-1:0];
                        r_o_y       <= r_ry[OUT_POS_W-1:0];
                        r_o_type    <= r_hit;
                        r_o_dist    <= r_dist;
                        r_o_ofs     <= r_ofs;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_CLEAR;
            endcase
        end
    end

    assign o_ready          = (r_state == ST_IDLE);
    assign o_valid          = r_out_valid;
    assign o_status         = r_o_status;
    assign o_hit_x          = $signed(r_o_x);
    assign o_hit_y          = $signed(r_o_y);
    assign o_hit_type       = $signed(r_o_type);
    assign o_distance       = r_o_dist;
    assign o_texture_offset = r_o_ofs;
endmodule
`default_nettype wire

// ===== sv/gcr_checker.sv =====
// Port-level checks for the grid ray caster, bound to the top level.
`default_nettype none
module gcr_checker (
    input wire logic                                  i_clk,
    input wire logic                                  i_rst_n,
    input wire logic                                  i_valid,
    input wire logic                                  o_ready,
    input wire logic                                  o_valid,
    input wire logic                                  i_ready,
    input wire logic             [1:0]                o_status,
    input wire logic signed      [gcr_pkg::OUT_POS_W-1:0] o_hit_x,
    input wire logic signed      [gcr_pkg::OUT_POS_W-1:0] o_hit_y,
    input wire logic signed      [gcr_pkg::CV_W-1:0]  o_hit_type,
    input wire logic             [gcr_pkg::DIST_W-1:0] o_distance,
    input wire logic             [gcr_pkg::OFS_W-1:0] o_texture_offset
);
    import gcr_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status) && $stable(o_distance))
        else $error("result changed while stalled");

    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_ready)
        else $error("item accepted during map clear");

    a_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == STAT_WRITTEN) |->
            (o_hit_x == '0) && (o_hit_y == '0) && (o_hit_type == '0) &&
            (o_distance == '0) && (o_texture_offset == '0))
        else $error("write result not zero");

    a_escape_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == STAT_ESCAPED) |->
            (o_distance == '0) && (o_texture_offset == '0))
        else $error("escaped ray carries distance");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == STAT_WRITTEN) || (o_status == STAT_ESCAPED) ||
                    (o_status == STAT_HIT))
        else $error("bad status code");
endmodule

bind grid_ray_caster_top gcr_checker u_gcr_checker (.*);
`default_nettype wire

// ===== bench/testbench.sv =====
// Grid ray caster testbench: directed table then random items, checked by predictor or table.
`timescale 1ns / 1ps
module testbench;
    import gcr_pkg::*;

    localparam int WATCHDOG_LIMIT = 600000;
    localparam int DRAIN_CYCLES   = 400;

    typedef struct packed {
        logic [1:0]  status;
        logic [14:0] hx;
        logic [14:0] hy;
        logic [7:0]  htype;
        logic [30:0] dlen;
        logic [5:0]  ofs;
    } ray_res_t;

    typedef struct {
        logic                func;
        logic signed [13:0]  x;
        logic signed [13:0]  y;
        logic signed [17:0]  s;
        logic signed [17:0]  c;
        logic signed [7:0]   v;
        bit                  typed;
        ray_res_t            res;
    } stim_row_t;

    logic i_clk, i_rst_n, i_valid, o_ready, i_func, o_valid, i_ready;
    logic signed [ORG_W-1:0]     i_origin_x, i_origin_y;
    logic signed [TRIG_W-1:0]    i_sine, i_cosine;
    logic signed [CV_W-1:0]      i_cell_value;
    logic [1:0]                  o_status;
    logic signed [OUT_POS_W-1:0] o_hit_x, o_hit_y;
    logic signed [CV_W-1:0]      o_hit_type;
    logic [DIST_W-1:0]           o_distance;
    logic [OFS_W-1:0]            o_texture_offset;

    byte       map_copy [MAP_DEPTH];
    ray_res_t  pending_results [$];
    stim_row_t dir_rows [$];
    int        errors = 0;
    int        idle_cnt = 0;
    bit        calm = 0;

    grid_ray_caster_top dut (.*);

    always begin
        i_clk = 1'b1; #2;
        i_clk = 1'b0; #2;
    end

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH %s: got %0h expected %0h", what, got, want);
        errors++;
    endtask

    function automatic int cell_read(longint px, longint py);
        if (px < 0 || py < 0 || px >= MAP_LIM || py >= MAP_LIM) return -1;
        return map_copy[(py >> 6) * MAP_CELLS + (px >> 6)];
    endfunction

    function automatic bit [31:0] reach_len(longint delta, longint comp);
        longint q;
        q = (delta * 65536) / comp;
        return q[31:0];
    endfunction

    function automatic ray_res_t ray_predict(stim_row_t it);
        ray_res_t  r;
        longint    x0, y0, s, c, rx, ry, ny, nx, dyb, dxb, lim, q;
        int        hit;
        bit [31:0] ylen, xlen, dlen_q;
        logic [1:0] st;
        longint    ofs;
        bit        done;
        x0 = it.x; y0 = it.y; s = it.s; c = it.c;
        r = '0;
        if (!it.func) begin
            if (x0 >= 0 && y0 >= 0 && x0 < MAP_LIM && y0 < MAP_LIM)
                map_copy[(y0 >> 6) * MAP_CELLS + (x0 >> 6)] = it.v;
            r.status = STAT_WRITTEN;
            return r;
        end
        rx = x0; ry = y0; hit = 0; st = STAT_ESCAPED; ofs = 0; dlen_q = 0; done = 0;
        ny = (s > 0) ? 64 : -1;
        nx = (c > 0) ? 64 : -1;
        if (s == 0) s = 1;
        if (c == 0) c = 1;
        lim = MAP_LIM;
        for (int k = 0; k < MAX_STEPS && !done; k++) begin
            dyb = ny - (ry & 63);
            dxb = nx - (rx & 63);
            ylen = reach_len(dyb, s);
            xlen = reach_len(dxb, c);
            if (xlen < ylen) begin
                rx += dxb;
                ry += (dxb * s) / c;
                hit = cell_read(rx, ry);
                if (hit > 0) begin
                    ofs = ry & 63;
                    q = ((rx - x0) * 65536) / c;
                    dlen_q = q[31:0];
                    st = STAT_HIT;
                    done = 1;
                end
            end else begin
                rx += (dyb * c) / s;
                ry += dyb;
                hit = cell_read(rx, ry);
                if (hit > 0) begin
                    ofs = rx & 63;
                    q = ((ry - y0) * 65536) / s;
                    dlen_q = q[31:0];
                    st = STAT_HIT;
                    done = 1;
                end
            end
            if (!done && hit == -1 && ((s < 0 && ry < 0) || (s > 0 && ry >= lim) ||
                                       (c < 0 && rx < 0) || (c > 0 && rx >= lim)))
                done = 1;
        end
        r.status = st;
        r.hx = rx[14:0];
        r.hy = ry[14:0];
        r.htype = hit[7:0];
        r.dlen = dlen_q[30:0];
        r.ofs = ofs[5:0];
        return r;
    endfunction

    function automatic void add_row(bit f, int x, int y, int s, int c, int v, bit typed,
                                    logic [1:0] st, int hx, int hy, int ht);
        stim_row_t row;
        row.func = f; row.x = x; row.y = y; row.s = s; row.c = c; row.v = v;
        row.typed = typed;
        row.res = '0;
        row.res.status = st;
        row.res.hx = hx;
        row.res.hy = hy;
        row.res.htype = ht;
        dir_rows.push_back(row);
    endfunction

    function automatic logic signed [17:0] rand_trig();
        case ($urandom_range(9))
            0: return 18'sd0;
            1: return 18'sd65536;
            2: return -18'sd65536;
            default: return $urandom_range(131072) - 65536;
        endcase
    endfunction

    task automatic send_item(stim_row_t it);
        ray_res_t want;
        while (!calm && $urandom_range(99) < 30) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_func       <= it.func;
        i_origin_x   <= it.x;
        i_origin_y   <= it.y;
        i_sine       <= it.s;
        i_cosine     <= it.c;
        i_cell_value <= it.v;
        do @(posedge i_clk); while (!o_ready);
        want = ray_predict(it);
        pending_results.push_back(it.typed ? it.res : want);
    endtask

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cnt <= 0;
        else idle_cnt <= idle_cnt + 1;
        if (idle_cnt > WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        ray_res_t want;
        i_ready <= calm || ($urandom_range(99) >= 30);
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", o_status, 0);
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status) report_mismatch("status", o_status, want.status);
                if (o_hit_x !== want.hx) report_mismatch("hit_x", o_hit_x, want.hx);
                if (o_hit_y !== want.hy) report_mismatch("hit_y", o_hit_y, want.hy);
                if (o_hit_type !== want.htype)
                    report_mismatch("hit_type", o_hit_type, want.htype);
                if (o_distance !== want.dlen)
                    report_mismatch("distance", o_distance, want.dlen);
                if (o_texture_offset !== want.ofs)
                    report_mismatch("texture_offset", o_texture_offset, want.ofs);
            end
        end
    end

    initial begin
        stim_row_t it;
        int        sel;
        i_rst_n = 1'b0; i_valid = 1'b0; i_ready = 1'b0; i_func = 1'b0;
        i_origin_x = '0; i_origin_y = '0; i_sine = '0; i_cosine = '0; i_cell_value = '0;
        foreach (map_copy[k]) map_copy[k] = 0;

        // runaway ray first, while the map is empty
        add_row(1, 100, 100, 0, 0, 0, 0, STAT_ESCAPED, 0, 0, 0);
        add_row(1, -4096, -4096, -65536, -65536, 0, 1, STAT_ESCAPED, -4097, -4097, -1);
        add_row(0, 0, 0, 0, 0, 127, 1, STAT_WRITTEN, 0, 0, 0);
        add_row(0, 4095, 4095, 0, 0, -128, 1, STAT_WRITTEN, 0, 0, 0);
        add_row(0, 8191, 8191, 0, 0, 5, 1, STAT_WRITTEN, 0, 0, 0);
        add_row(0, -4096, -4096, 0, 0, 7, 1, STAT_WRITTEN, 0, 0, 0);
        add_row(0, 4096, 0, 0, 0, 9, 1, STAT_WRITTEN, 0, 0, 0);
        add_row(0, 130, 70, 0, 0, 4, 1, STAT_WRITTEN, 0, 0, 0);
        add_row(0, 200, 10, 0, 0, 1, 1, STAT_WRITTEN, 0, 0, 0);
        add_row(0, 64, 0, 0, 0, -1, 1, STAT_WRITTEN, 0, 0, 0);
        add_row(1, 96, 96, 0, -65536, 0, 0, STAT_HIT, 0, 0, 0);
        add_row(1, 96, 96, -65536, 0, 0, 0, STAT_HIT, 0, 0, 0);
        add_row(1, 10, 100, 0, 65536, 0, 0, STAT_HIT, 0, 0, 0);
        add_row(1, 10, 10, 65536, 65536, 0, 0, STAT_HIT, 0, 0, 0);
        add_row(1, 8191, -4096, -65536, 65536, 0, 0, STAT_HIT, 0, 0, 0);
        add_row(1, 4000, 4000, 65536, 65536, 0, 0, STAT_HIT, 0, 0, 0);
        add_row(0, 4095, 4095, 0, 0, 0, 1, STAT_WRITTEN, 0, 0, 0);
        add_row(1, 70, 10, 46341, -46341, 0, 0, STAT_HIT, 0, 0, 0);
        add_row(1, 1000, 1000, 65536, 0, 0, 0, STAT_HIT, 0, 0, 0);
        add_row(1, 300, 40, -65536, -65536, 0, 0, STAT_HIT, 0, 0, 0);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[k]) send_item(dir_rows[k]);

        // wall ring on cell row 9 and cell column 9, round cells 0..8, keeps most rays short
        for (int k = 0; k < 19; k++) begin
            it.func = 0; it.typed = 0; it.s = rand_trig(); it.c = rand_trig();
            it.x = (k < 10) ? k * 64 + $urandom_range(63) : 9 * 64 + $urandom_range(63);
            it.y = (k < 10) ? 9 * 64 + $urandom_range(63) : (k - 10) * 64 + $urandom_range(63);
            it.v = $urandom_range(1, 127);
            send_item(it);
        end

        for (int n = 0; n < 250; n++) begin
            calm = (n >= 100 && n < 160);
            sel = $urandom_range(99);
            it.typed = 0;
            it.s = rand_trig();
            it.c = rand_trig();
            it.v = $urandom_range(255) - 128;
            if (sel < 55) begin
                it.func = 1;
                it.x = $urandom_range(575);
                it.y = $urandom_range(575);
            end else if (sel < 90) begin
                it.func = 0;
                it.x = $urandom_range(639);
                it.y = $urandom_range(639);
            end else begin
                it.func = (sel >= 95);
                it.x = $urandom_range(12287) - 4096;
                it.y = $urandom_range(12287) - 4096;
            end
            send_item(it);
        end
        calm = 0;
        i_valid <= 1'b0;

        wait (pending_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) $display("Verification passed");
        else $display("Verification failed");
        $finish;
    end
endmodule

// ===== files.f =====
sv/gcr_pkg.sv
sv/gcr_map_ram.sv
sv/gcr_divider.sv
sv/grid_ray_caster_top.sv
sv/gcr_checker.sv
bench/testbench.sv
